// ===== hw/rtl/dpprc_pkg.sv =====
// package for the drift-plus-penalty rate control unit
// holds widths, config register map, microcode types and the control program rom
`timescale 1ns / 1ps

package dpprc_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_WIDTH_DEF = 32;

    localparam int RATE_W     = 24;
    localparam int GAIN_W     = 24;
    localparam int WEIGHT_W   = 8;
    localparam int DIVB_W     = 8;
    localparam int OUT_Q_W    = 32;
    localparam int PROD_W     = GAIN_W + WEIGHT_W;
    localparam int NUM_FLOWS  = 3;
    localparam int FLOW_IDX_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int STEP_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_DIVISOR = 3'd5;

    localparam logic [GAIN_W-1:0]   GAIN_RST     = 24'd655360;
    localparam logic [WEIGHT_W-1:0] WEIGHT_1_RST = 8'd1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_2_RST = 8'd2;
    localparam logic [WEIGHT_W-1:0] WEIGHT_3_RST = 8'd2;
    localparam logic [RATE_W-1:0]   CAP_RST      = 24'd65536;
    localparam logic [DIVB_W-1:0]   DIVB_RST     = 8'd5;

    localparam logic [FLOW_IDX_W-1:0] LAST_FLOW = 2'd2;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_QSUM,
        OP_QSUB,
        OP_MUL,
        OP_DIV_RATIO,
        OP_CHECK,
        OP_DIV_RATE,
        OP_SAT,
        OP_NEXT_FLOW,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_REQ,
        COND_DIV_BUSY,
        COND_SKIP_DIV,
        COND_MORE_FLOWS,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    typedef struct packed {
        logic req_valid;
        logic div_busy;
        logic skip_div;
        logic more_flows;
        logic out_busy;
    } status_t;

    typedef struct packed {
        logic [GAIN_W-1:0]   penalty_gain;
        logic [WEIGHT_W-1:0] weight_one;
        logic [WEIGHT_W-1:0] weight_two;
        logic [WEIGHT_W-1:0] weight_three;
        logic [RATE_W-1:0]   capacity;
        logic [DIVB_W-1:0]   rate_divisor;
    } cfg_t;

    localparam step_t STEP_IDLE    = 4'd0;
    localparam step_t STEP_QSUM    = 4'd1;
    localparam step_t STEP_QSUB    = 4'd2;
    localparam step_t STEP_MUL     = 4'd3;
    localparam step_t STEP_DIVA    = 4'd4;
    localparam step_t STEP_WAITA   = 4'd5;
    localparam step_t STEP_CHECK   = 4'd6;
    localparam step_t STEP_DIVB    = 4'd7;
    localparam step_t STEP_WAITB   = 4'd8;
    localparam step_t STEP_SAT     = 4'd9;
    localparam step_t STEP_NEXT    = 4'd10;
    localparam step_t STEP_WAITOUT = 4'd11;
    localparam step_t STEP_EMIT    = 4'd12;

    function automatic ucode_t ucode_rom(step_t addr);
        ucode_t word;
        unique case (addr)
            STEP_IDLE:    word = '{OP_ACCEPT,    COND_NO_REQ,     STEP_IDLE};
            STEP_QSUM:    word = '{OP_QSUM,      COND_NONE,       STEP_IDLE};
            STEP_QSUB:    word = '{OP_QSUB,      COND_NONE,       STEP_IDLE};
            STEP_MUL:     word = '{OP_MUL,       COND_NONE,       STEP_IDLE};
            STEP_DIVA:    word = '{OP_DIV_RATIO, COND_NONE,       STEP_IDLE};
            STEP_WAITA:   word = '{OP_NOP,       COND_DIV_BUSY,   STEP_WAITA};
            STEP_CHECK:   word = '{OP_CHECK,     COND_SKIP_DIV,   STEP_NEXT};
            STEP_DIVB:    word = '{OP_DIV_RATE,  COND_NONE,       STEP_IDLE};
            STEP_WAITB:   word = '{OP_NOP,       COND_DIV_BUSY,   STEP_WAITB};
            STEP_SAT:     word = '{OP_SAT,       COND_NONE,       STEP_IDLE};
            STEP_NEXT:    word = '{OP_NEXT_FLOW, COND_MORE_FLOWS, STEP_MUL};
            STEP_WAITOUT: word = '{OP_NOP,       COND_OUT_BUSY,   STEP_WAITOUT};
            STEP_EMIT:    word = '{OP_EMIT,      COND_ALWAYS,     STEP_IDLE};
            default:      word = '{OP_NOP,       COND_ALWAYS,     STEP_IDLE};
        endcase
        return word;
    endfunction

endpackage

// ===== hw/rtl/dpprc_divider.sv =====
// restoring unsigned divider, one quotient bit per cycle
// standalone, no package dependency
`timescale 1ns / 1ps

module dpprc_divider #(
    parameter int DIVIDEND_W = 48,
    parameter int DIVISOR_W  = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;

    logic [DIVISOR_W:0] trial;
    logic [DIVISOR_W:0] diff;
    logic               ge;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[DIVIDEND_W-2:0], ge};
            rem_next  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/dpprc_datapath.sv =====
// datapath of the rate control unit: queue, rates, peak, multiplier, output register
// depends on dpprc_pkg and dpprc_divider, driven by the microcode word
`timescale 1ns / 1ps

module dpprc_datapath #(
    parameter int FRAC_BITS   = dpprc_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_WIDTH = dpprc_pkg::QUEUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dpprc_pkg::ucode_t             cw,
    input  dpprc_pkg::cfg_t               cfg,
    output dpprc_pkg::status_t            status,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_restart,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dpprc_pkg::OUT_Q_W-1:0] m_queue_level,
    output logic [dpprc_pkg::RATE_W-1:0]  m_rate_one,
    output logic [dpprc_pkg::RATE_W-1:0]  m_rate_two,
    output logic [dpprc_pkg::RATE_W-1:0]  m_rate_three,
    output logic [dpprc_pkg::OUT_Q_W-1:0] m_peak_queue
);

    import dpprc_pkg::*;

    localparam int QW    = QUEUE_WIDTH;
    localparam int SUM_W = QW + 2;
    localparam int NUM_W = PROD_W + FRAC_BITS;
    localparam logic [NUM_W-1:0] ONE_FIX = {{(NUM_W-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic [QW-1:0]         backlog_reg, backlog_next;
    logic [QW-1:0]         peak_reg, peak_next;
    logic [RATE_W-1:0]     rate_reg [NUM_FLOWS];
    logic [RATE_W-1:0]     rate_next [NUM_FLOWS];
    logic [FLOW_IDX_W-1:0] flow_idx_reg, flow_idx_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_Q_W-1:0]    out_queue_reg, out_queue_next;
    logic [OUT_Q_W-1:0]    out_peak_reg, out_peak_next;
    logic [RATE_W-1:0]     out_r1_reg, out_r1_next;
    logic [RATE_W-1:0]     out_r2_reg, out_r2_next;
    logic [RATE_W-1:0]     out_r3_reg, out_r3_next;

    logic                  accept;
    logic [WEIGHT_W-1:0]   weight_sel;
    logic [SUM_W-1:0]      cap_ext;
    logic [SUM_W-1:0]      diff;
    logic [QW-1:0]         q_new;
    logic [QW+OUT_Q_W-1:0] q_wide;
    logic [QW+OUT_Q_W-1:0] peak_wide;
    logic                  div_start;
    logic [NUM_W-1:0]      div_dividend;
    logic [QW-1:0]         div_divisor;
    logic                  div_busy;
    logic [NUM_W-1:0]      div_quot;
    logic                  ratio_low;

    dpprc_divider #(
        .DIVIDEND_W (NUM_W),
        .DIVISOR_W  (QW)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    assign s_ready = (cw.op == OP_ACCEPT);
    assign accept  = s_ready && s_valid;

    always_comb begin
        unique case (flow_idx_reg)
            2'd0:    weight_sel = cfg.weight_one;
            2'd1:    weight_sel = cfg.weight_two;
            default: weight_sel = cfg.weight_three;
        endcase
    end

    // new backlog: floor at zero, saturate, empty queue reads as one lsb
    assign cap_ext = SUM_W'(cfg.capacity);
    assign diff    = (sum_reg > cap_ext) ? (sum_reg - cap_ext) : '0;
    always_comb begin
        if (|diff[SUM_W-1:QW]) begin
            q_new = '1;
        end else begin
            q_new = diff[QW-1:0];
        end
        if (q_new == '0) begin
            q_new = QW'(1);
        end
    end

    assign q_wide    = {{OUT_Q_W{1'b0}}, backlog_reg};
    assign peak_wide = {{OUT_Q_W{1'b0}}, peak_reg};
    assign ratio_low = (div_quot <= ONE_FIX);

    always_comb begin
        div_start    = 1'b0;
        div_dividend = {prod_reg, {FRAC_BITS{1'b0}}};
        div_divisor  = backlog_reg;
        if (cw.op == OP_DIV_RATIO) begin
            div_start = 1'b1;
        end else if (cw.op == OP_DIV_RATE) begin
            div_start    = 1'b1;
            div_dividend = div_quot - ONE_FIX;
            div_divisor  = QW'(cfg.rate_divisor);
        end
    end

    always_comb begin
        backlog_next   = backlog_reg;
        peak_next      = peak_reg;
        rate_next      = rate_reg;
        flow_idx_next  = flow_idx_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        out_queue_next = out_queue_reg;
        out_peak_next  = out_peak_reg;
        out_r1_next    = out_r1_reg;
        out_r2_next    = out_r2_reg;
        out_r3_next    = out_r3_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        unique case (cw.op)
            OP_ACCEPT: begin
                if (accept && s_restart) begin
                    backlog_next = '0;
                    peak_next    = '0;
                    rate_next    = '{default: '0};
                end
            end
            OP_QSUM: begin
                sum_next = SUM_W'(backlog_reg) + SUM_W'(rate_reg[0])
                         + SUM_W'(rate_reg[1]) + SUM_W'(rate_reg[2]);
            end
            OP_QSUB: begin
                backlog_next  = q_new;
                peak_next     = (q_new > peak_reg) ? q_new : peak_reg;
                flow_idx_next = '0;
            end
            OP_MUL: begin
                prod_next = PROD_W'(cfg.penalty_gain) * PROD_W'(weight_sel);
            end
            OP_CHECK: begin
                if (ratio_low) begin
                    rate_next[flow_idx_reg] = '0;
                end else if (cfg.rate_divisor == '0) begin
                    rate_next[flow_idx_reg] = cfg.capacity;
                end
            end
            OP_SAT: begin
                rate_next[flow_idx_reg] = (div_quot > NUM_W'(cfg.capacity))
                                        ? cfg.capacity : div_quot[RATE_W-1:0];
            end
            OP_NEXT_FLOW: begin
                if (flow_idx_reg != LAST_FLOW) begin
                    flow_idx_next = flow_idx_reg + 1'b1;
                end
            end
            OP_EMIT: begin
                out_queue_next = q_wide[OUT_Q_W-1:0];
                out_peak_next  = peak_wide[OUT_Q_W-1:0];
                out_r1_next    = rate_reg[0];
                out_r2_next    = rate_reg[1];
                out_r3_next    = rate_reg[2];
                m_valid_next   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            backlog_reg  <= '0;
            peak_reg     <= '0;
            rate_reg     <= '{default: '0};
            flow_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            backlog_reg  <= backlog_next;
            peak_reg     <= peak_next;
            rate_reg     <= rate_next;
            flow_idx_reg <= flow_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg       <= sum_next;
        prod_reg      <= prod_next;
        out_queue_reg <= out_queue_next;
        out_peak_reg  <= out_peak_next;
        out_r1_reg    <= out_r1_next;
        out_r2_reg    <= out_r2_next;
        out_r3_reg    <= out_r3_next;
    end

    assign status.req_valid  = s_valid;
    assign status.div_busy   = div_busy;
    assign status.skip_div   = ratio_low || (cfg.rate_divisor == '0);
    assign status.more_flows = (flow_idx_reg != LAST_FLOW);
    assign status.out_busy   = m_valid_reg && !m_ready;

    assign m_valid       = m_valid_reg;
    assign m_queue_level = out_queue_reg;
    assign m_peak_queue  = out_peak_reg;
    assign m_rate_one    = out_r1_reg;
    assign m_rate_two    = out_r2_reg;
    assign m_rate_three  = out_r3_reg;

endmodule

// ===== hw/rtl/dpprc_sequencer.sv =====
// microcode sequencer: step counter, control rom and conditional jumps
// depends on dpprc_pkg for the control word, status flags and program
`timescale 1ns / 1ps

module dpprc_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  dpprc_pkg::status_t  status,
    output dpprc_pkg::ucode_t   cw
);

    import dpprc_pkg::*;

    step_t  step_reg, step_next;
    ucode_t word;
    logic   take_jump;

    assign word = ucode_rom(step_reg);

    always_comb begin
        unique case (word.cond)
            COND_NONE:       take_jump = 1'b0;
            COND_ALWAYS:     take_jump = 1'b1;
            COND_NO_REQ:     take_jump = !status.req_valid;
            COND_DIV_BUSY:   take_jump = status.div_busy;
            COND_SKIP_DIV:   take_jump = status.skip_div;
            COND_MORE_FLOWS: take_jump = status.more_flows;
            COND_OUT_BUSY:   take_jump = status.out_busy;
            default:         take_jump = 1'b1;
        endcase
    end

    always_comb begin
        step_next = take_jump ? word.target : step_t'(step_reg + 1'b1);
    end

    always_comb begin
        cw = word;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== hw/rtl/drift_plus_penalty_rate_control_unit.sv =====
// drift-plus-penalty rate control: each request is one tick and gives one result
// per request: queue sum, backlog update, then per flow a multiply and a ratio division
// and, unless the rate comes out zero or at capacity, a second division, all on the
// shared one-bit-per-cycle divider; the result is loaded once the output is free
// a new request is taken only after that load, also while the last result waits
// synchronous active-low reset: queue, rates and peak cleared, config to defaults
`timescale 1ns / 1ps

module drift_plus_penalty_rate_control_unit #(
    parameter int FRAC_BITS   = dpprc_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_WIDTH = dpprc_pkg::QUEUE_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [dpprc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dpprc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_restart,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [dpprc_pkg::OUT_Q_W-1:0]    m_queue_level,
    output logic [dpprc_pkg::RATE_W-1:0]     m_rate_one,
    output logic [dpprc_pkg::RATE_W-1:0]     m_rate_two,
    output logic [dpprc_pkg::RATE_W-1:0]     m_rate_three,
    output logic [dpprc_pkg::OUT_Q_W-1:0]    m_peak_queue
);

    import dpprc_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    ucode_t  cw;
    status_t status;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PENALTY_GAIN: cfg_next.penalty_gain = cfg_wdata[GAIN_W-1:0];
                CFG_WEIGHT_ONE:   cfg_next.weight_one   = cfg_wdata[WEIGHT_W-1:0];
                CFG_WEIGHT_TWO:   cfg_next.weight_two   = cfg_wdata[WEIGHT_W-1:0];
                CFG_WEIGHT_THREE: cfg_next.weight_three = cfg_wdata[WEIGHT_W-1:0];
                CFG_CAPACITY:     cfg_next.capacity     = cfg_wdata[RATE_W-1:0];
                CFG_RATE_DIVISOR: cfg_next.rate_divisor = cfg_wdata[DIVB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{GAIN_RST, WEIGHT_1_RST, WEIGHT_2_RST, WEIGHT_3_RST,
                         CAP_RST, DIVB_RST};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    dpprc_sequencer u_sequencer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cw      (cw)
    );

    dpprc_datapath #(
        .FRAC_BITS   (FRAC_BITS),
        .QUEUE_WIDTH (QUEUE_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cw            (cw),
        .cfg           (cfg_reg),
        .status        (status),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_queue_level (m_queue_level),
        .m_rate_one    (m_rate_one),
        .m_rate_two    (m_rate_two),
        .m_rate_three  (m_rate_three),
        .m_peak_queue  (m_peak_queue)
    );

    // a request starts a program run, so ready drops right after it
    a_ready_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready still high after an accepted request");

    // divider is only started once the previous division has finished
    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.op == OP_DIV_RATIO || cw.op == OP_DIV_RATE) |-> !status.div_busy)
        else $error("divider started while busy");

    // a result is only loaded into a free output register
    a_emit_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.op == OP_EMIT) |-> !(m_valid && !m_ready))
        else $error("result overwrote one not yet taken");

endmodule
